FILE: rtl/ppae_pkg.sv
`default_nettype none
package ppae_pkg;

    localparam int SLOTS    = 256;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int CNT_W    = IDX_W + 1;
    localparam int LIFE_W   = 9;
    localparam int ACC_W    = 17;
    localparam int TICKS_PER_SECOND = 30;

    localparam logic [LIFE_W-1:0] LIFE_TICKS = LIFE_W'(300);
    localparam int DT_Q16   = (65536 + TICKS_PER_SECOND / 2) / TICKS_PER_SECOND;
    localparam int ACC_DV   = 10 * DT_Q16;
    localparam logic signed [31:0] SPAWN_VEL = 32'sd655360;
    localparam logic [ACC_W-1:0] ACC_ONE = ACC_W'(256 * TICKS_PER_SECOND);

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic REG_EMIT_RATE  = 1'b0;
    localparam logic REG_POOL_LIMIT = 1'b1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] vel;
        logic [LIFE_W-1:0]  life;
    } part_t;

    typedef struct packed {
        logic [CNT_W-1:0]   live;
        logic [CNT_W-1:0]   emitted;
        logic               valid;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [LIFE_W-1:0]  life;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_DAT,
        ST_AGE_RD,
        ST_AGE_EV,
        ST_EMIT,
        ST_INT,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

FILE: rtl/particle_pool_age_emit_integrate.sv
`default_nettype none
// Channel  | Ports           | Contents (lowest bit up)
// ---------+-----------------+-----------------------------------------------
// request  | s_t*            | tuser: kind; tdata: spawn_x, spawn_y, spawn_z,
//          |                 |   read_index
// result   | m_t*            | tuser: valid_res; tdata: live_count, emitted,
//          |                 |   pos_x, pos_y, pos_z, life_left, zero pad
// config   | cfg_*           | 0 emit_rate, 1 pool_limit
//
// A read makes one memory read. A tick ages each live slot (one memory
// read, one write back), then takes whole particles from the accumulator
// one at a time, then passes every slot through the integrate pipeline,
// all through the single particle memory port pair.
// One request is worked at a time; the next is taken while a result waits.
// Reset clears live count and accumulator; memory contents are not cleared.
module particle_pool_age_emit_integrate
    import ppae_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [103:0] s_tdata,   // spawn_x, spawn_y, spawn_z, read_index
    input  wire logic         s_tuser,   // kind
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // live_count, emitted, pos_x, pos_y,
                                         // pos_z, life_left, zero pad
    output logic              m_tuser,   // valid_res
    input  wire logic         cfg_we,
    input  wire logic         cfg_addr,
    input  wire logic [15:0]  cfg_wdata
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   live_reg, live_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [15:0]        rate_reg;
    logic [CNT_W-1:0]   limit_reg;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   wr_reg, wr_next;
    logic [CNT_W-1:0]   emitted_reg, emitted_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic signed [31:0] sx_reg, sy_reg, sz_reg;
    logic               rvalid_reg, rvalid_next;
    res_t               res_reg, res_next;
    res_t               mres_reg, mres_next;
    logic               mvalid_reg, mvalid_next;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr, mem_raddr;
    part_t              mem_wdata, mem_rdata;
    logic               int_valid;
    part_t              int_part;
    logic [CNT_W-1:0]   lim;
    logic               accept;

    ppae_ram #(
        .ADDR_W(IDX_W),
        .DATA_W($bits(part_t))
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ppae_integ u_integ (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rvalid_reg),
        .in_part   (mem_rdata),
        .out_valid (int_valid),
        .out_part  (int_part)
    );

    assign lim    = (limit_reg > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : limit_reg;
    assign accept = s_tvalid && s_tready;

    always_comb begin
        state_next   = state_reg;
        live_next    = live_reg;
        acc_next     = acc_reg;
        idx_next     = idx_reg;
        wr_next      = wr_reg;
        emitted_next = emitted_reg;
        rd_idx_next  = rd_idx_reg;
        rvalid_next  = 1'b0;
        res_next     = res_reg;
        mres_next    = mres_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        s_tready     = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg[IDX_W-1:0];
        mem_wdata    = mem_rdata;
        mem_raddr    = idx_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                mem_raddr = s_tdata[103:96];
                if (accept) begin
                    rd_idx_next  = s_tdata[103:96];
                    idx_next     = '0;
                    emitted_next = '0;
                    if (s_tuser == KIND_READ) begin
                        state_next = ST_RD_DAT;
                    end else begin
                        state_next = ST_AGE_RD;
                    end
                end
            end
            ST_RD_DAT: begin
                res_next         = '0;
                res_next.live    = live_reg;
                if (CNT_W'(rd_idx_reg) < live_reg) begin
                    res_next.valid = 1'b1;
                    res_next.x     = mem_rdata.x;
                    res_next.y     = mem_rdata.y;
                    res_next.z     = mem_rdata.z;
                    res_next.life  = mem_rdata.life;
                end
                state_next = ST_DONE;
            end
            ST_AGE_RD: begin
                if (idx_reg < live_reg) begin
                    state_next = ST_AGE_EV;
                end else begin
                    acc_next   = acc_reg + ACC_W'(rate_reg);
                    state_next = ST_EMIT;
                end
            end
            ST_AGE_EV: begin
                if (mem_rdata.life != '0) begin
                    mem_we         = 1'b1;
                    mem_wdata.life = mem_rdata.life - LIFE_W'(1);
                    idx_next       = idx_reg + CNT_W'(1);
                    state_next     = ST_AGE_RD;
                end else begin
                    // drop: pull the last particle into this slot and age it here
                    live_next = live_reg - CNT_W'(1);
                    mem_raddr = live_next[IDX_W-1:0];
                    if (idx_reg >= live_next) begin
                        acc_next   = acc_reg + ACC_W'(rate_reg);
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (acc_reg >= ACC_ONE) begin
                    acc_next = acc_reg - ACC_ONE;
                    if (live_reg < lim) begin
                        mem_we         = 1'b1;
                        mem_waddr      = live_reg[IDX_W-1:0];
                        mem_wdata.x    = sx_reg;
                        mem_wdata.y    = sy_reg;
                        mem_wdata.z    = sz_reg;
                        mem_wdata.vel  = SPAWN_VEL;
                        mem_wdata.life = LIFE_TICKS;
                        live_next      = live_reg + CNT_W'(1);
                        emitted_next   = emitted_reg + CNT_W'(1);
                    end
                end else begin
                    idx_next   = '0;
                    wr_next    = '0;
                    state_next = ST_INT;
                end
            end
            ST_INT: begin
                if (idx_reg < live_reg) begin
                    rvalid_next = 1'b1;
                    idx_next    = idx_reg + CNT_W'(1);
                end
                if (int_valid) begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_reg[IDX_W-1:0];
                    mem_wdata = int_part;
                    wr_next   = wr_reg + CNT_W'(1);
                end else if (wr_reg == live_reg) begin
                    res_next         = '0;
                    res_next.live    = live_reg;
                    res_next.emitted = emitted_reg;
                    state_next       = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    mres_next   = res_reg;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            live_reg   <= '0;
            acc_reg    <= '0;
            rate_reg   <= 16'd256;
            limit_reg  <= CNT_W'(100);
            rvalid_reg <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            live_reg   <= live_next;
            acc_reg    <= acc_next;
            rvalid_reg <= rvalid_next;
            mvalid_reg <= mvalid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_EMIT_RATE:  rate_reg  <= cfg_wdata;
                    REG_POOL_LIMIT: limit_reg <= cfg_wdata[CNT_W-1:0];
                    default:        rate_reg  <= rate_reg;
                endcase
            end
        end
        idx_reg     <= idx_next;
        wr_reg      <= wr_next;
        emitted_reg <= emitted_next;
        rd_idx_reg  <= rd_idx_next;
        res_reg     <= res_next;
        mres_reg    <= mres_next;
        if (accept) begin
            sx_reg <= s_tdata[31:0];
            sy_reg <= s_tdata[63:32];
            sz_reg <= s_tdata[95:64];
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tuser  = mres_reg.valid;
    assign m_tdata  = {5'b0, mres_reg.life, mres_reg.z, mres_reg.y, mres_reg.x,
                       mres_reg.emitted, mres_reg.live};

endmodule
`default_nettype wire

FILE: rtl/ppae_ram.sv
`default_nettype none
module ppae_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/ppae_integ.sv
`default_nettype none
module ppae_integ
    import ppae_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    input  wire part_t in_part,
    output logic       out_valid,
    output part_t      out_part
);

    logic               v1_reg;
    logic               v2_reg;
    part_t              p1_reg;
    part_t              p2_reg;
    logic signed [44:0] prod_reg;
    logic signed [44:0] prod_next;
    logic signed [12:0] dt_s;
    logic signed [44:0] rnd;
    logic signed [28:0] step;
    logic signed [33:0] ysum;
    logic signed [32:0] vdiff;
    part_t              p2_next;

    assign dt_s      = 13'(DT_Q16);
    assign prod_next = in_part.vel * dt_s;

    always_comb begin
        p2_next = p1_reg;
        // round half up, then floor by arithmetic shift
        rnd   = prod_reg + 45'sd32768;
        step  = rnd[44:16];
        ysum  = 34'(p1_reg.y) + 34'(step);
        vdiff = 33'(p1_reg.vel) - 33'(ACC_DV);
        if ((ysum[33] == ysum[32]) && (ysum[32] == ysum[31])) begin
            p2_next.y = ysum[31:0];
        end else begin
            p2_next.y = ysum[33] ? 32'sh80000000 : 32'sh7fffffff;
        end
        if (vdiff[32] == vdiff[31]) begin
            p2_next.vel = vdiff[31:0];
        end else begin
            p2_next.vel = 32'sh80000000;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
        prod_reg <= prod_next;
        p1_reg   <= in_part;
        p2_reg   <= p2_next;
    end

    assign out_valid = v2_reg;
    assign out_part  = p2_reg;

endmodule
`default_nettype wire

FILE: dv/tb_particle_pool_age_emit_integrate.sv
`timescale 1ns / 100ps
module tb_particle_pool_age_emit_integrate;
    import ppae_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    logic [103:0] s_tdata = '0;   // spawn_x, spawn_y, spawn_z, read_index
    logic         s_tuser = 1'b0; // kind
    wire          m_tvalid;
    logic         m_tready = 1'b0;
    wire  [127:0] m_tdata;        // live_count, emitted, pos_x, pos_y, pos_z, life_left
    wire          m_tuser;        // valid_res
    logic         cfg_we = 1'b0;
    logic         cfg_addr = 1'b0;
    logic [15:0]  cfg_wdata = '0;

    particle_pool_age_emit_integrate dut (.*);

    always #2 aclk = ~aclk;

    // pool mirror
    logic signed [31:0] pool_x [SLOTS];
    logic signed [31:0] pool_y [SLOTS];
    logic signed [31:0] pool_z [SLOTS];
    logic signed [31:0] pool_vel [SLOTS];
    int                 pool_life [SLOTS];
    int                 pool_live = 0;
    int                 emit_accum = 0;
    int                 emit_rate = 256;
    int                 pool_limit = 100;

    res_t pending_results [$];
    int   errors = 0;
    bit   calm = 1'b0;
    int   hold_off = 0;

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic res_t predict_request(logic kind, logic [103:0] d);
        res_t r;
        int i, whole, lim, room, ne;
        longint step;
        r = '0;
        if (kind == KIND_READ) begin
            i = int'(d[103:96]);
            r.live = CNT_W'(pool_live);
            if (i < pool_live) begin
                r.valid = 1'b1;
                r.x = pool_x[i];
                r.y = pool_y[i];
                r.z = pool_z[i];
                r.life = LIFE_W'(pool_life[i]);
            end
            return r;
        end
        // age, moving the last particle into any slot that dies
        i = 0;
        while (i < pool_live) begin
            pool_life[i]--;
            if (pool_life[i] < 0) begin
                pool_live--;
                pool_x[i] = pool_x[pool_live];
                pool_y[i] = pool_y[pool_live];
                pool_z[i] = pool_z[pool_live];
                pool_vel[i] = pool_vel[pool_live];
                pool_life[i] = pool_life[pool_live];
            end else begin
                i++;
            end
        end
        emit_accum += emit_rate;
        whole = emit_accum / int'(ACC_ONE);
        emit_accum -= whole * int'(ACC_ONE);
        lim = (pool_limit > SLOTS) ? SLOTS : pool_limit;
        room = (pool_live < lim) ? lim - pool_live : 0;
        ne = (whole < room) ? whole : room;
        for (i = pool_live; i < pool_live + ne; i++) begin
            pool_x[i] = d[31:0];
            pool_y[i] = d[63:32];
            pool_z[i] = d[95:64];
            pool_vel[i] = SPAWN_VEL;
            pool_life[i] = int'(LIFE_TICKS);
        end
        pool_live += ne;
        for (i = 0; i < pool_live; i++) begin
            step = (longint'(pool_vel[i]) * DT_Q16 + 32768) >>> 16;
            pool_y[i] = clamp32(longint'(pool_y[i]) + step);
            pool_vel[i] = clamp32(longint'(pool_vel[i]) - ACC_DV);
        end
        r.live = CNT_W'(pool_live);
        r.emitted = CNT_W'(ne);
        return r;
    endfunction

    task automatic send_request(logic kind, logic [31:0] x, logic [31:0] y,
                                logic [31:0] z, logic [7:0] idx);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {idx, z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_request(kind, {idx, z, y, x}));
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_reg(logic addr, logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (addr == REG_EMIT_RATE) emit_rate = int'(v);
        else pool_limit = int'(v[8:0]);
        @(posedge aclk);
    endtask

    function automatic logic [31:0] spawn_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic tick();
        send_request(KIND_TICK, spawn_coord(), spawn_coord(), spawn_coord(), 8'($urandom));
    endtask

    task automatic read_slot(logic [7:0] idx);
        send_request(KIND_READ, $urandom, $urandom, $urandom, idx);
    endtask

    task automatic mixed_requests(int n, int read_pct);
        repeat (n) begin
            if ($urandom_range(0, 99) < read_pct)
                read_slot((pool_live > 0 && $urandom_range(0, 7) != 0)
                          ? 8'($urandom_range(0, pool_live - 1)) : 8'($urandom));
            else
                tick();
        end
    endtask

    task automatic test_empty_pool;
        read_slot(8'd0);
        read_slot(8'd255);
        tick();
        read_slot(8'd0);
        drain();
    endtask

    task automatic test_extremes;
        write_reg(REG_EMIT_RATE, 16'hFFFF);
        write_reg(REG_POOL_LIMIT, 16'd256);
        send_request(KIND_TICK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'hFF);
        send_request(KIND_TICK, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'h00);
        read_slot(8'd0);
        read_slot(8'd9);
        read_slot(8'd255);
        repeat (3) tick();
        drain();
    endtask

    task automatic test_limits;
        // limit below the live count: nothing is emitted, nothing dies early
        write_reg(REG_POOL_LIMIT, 16'd3);
        repeat (2) tick();
        read_slot(8'd1);
        drain();
        write_reg(REG_POOL_LIMIT, 16'd0);
        tick();
        drain();
        write_reg(REG_POOL_LIMIT, 16'd511);
        repeat (3) tick();
        drain();
        write_reg(REG_EMIT_RATE, 16'd0);
        repeat (2) tick();
        read_slot(8'd2);
        drain();
    endtask

    task automatic test_backpressure;
        write_reg(REG_EMIT_RATE, 16'd40000);
        write_reg(REG_POOL_LIMIT, 16'd60);
        hold_off = 4000;
        mixed_requests(12, 50);
        drain();
    endtask

    task automatic test_random;
        write_reg(REG_EMIT_RATE, 16'd65535);
        write_reg(REG_POOL_LIMIT, 16'd256);
        mixed_requests(330, 25);
        drain();
        write_reg(REG_EMIT_RATE, 16'($urandom_range(0, 65535)));
        write_reg(REG_POOL_LIMIT, 16'($urandom_range(0, 256)));
        mixed_requests(330, 30);
        drain();
        write_reg(REG_EMIT_RATE, 16'd256);
        write_reg(REG_POOL_LIMIT, 16'd100);
        mixed_requests(300, 30);
        drain();
        calm = 1'b1;
        write_reg(REG_EMIT_RATE, 16'($urandom_range(7680, 65535)));
        write_reg(REG_POOL_LIMIT, 16'($urandom_range(128, 300)));
        mixed_requests(170, 40);
        drain();
    endtask

    // result side: check, then pick the next ready value
    initial begin
        int stall;
        res_t e;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    report("unexpected result", 1, 0);
                end else begin
                    e = pending_results.pop_front();
                    if (m_tdata[8:0] != e.live) report("live_count", m_tdata[8:0], e.live);
                    if (m_tdata[17:9] != e.emitted) report("emitted", m_tdata[17:9], e.emitted);
                    if (m_tuser != e.valid) report("valid_res", m_tuser, e.valid);
                    if (m_tdata[49:18] != e.x) report("pos_x", m_tdata[49:18], e.x);
                    if (m_tdata[81:50] != e.y) report("pos_y", m_tdata[81:50], e.y);
                    if (m_tdata[113:82] != e.z) report("pos_z", m_tdata[113:82], e.z);
                    if (m_tdata[122:114] != e.life)
                        report("life_left", m_tdata[122:114], e.life);
                end
            end
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(0, 13);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);
        test_empty_pool();
        test_extremes();
        test_limits();
        test_backpressure();
        test_random();
        repeat (50) @(posedge aclk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
